/* rtl/barometer_compensation_assert.svh */
// Assertion macros for the barometer compensation block.
`ifndef BAROMETER_COMPENSATION_ASSERT_SVH
`define BAROMETER_COMPENSATION_ASSERT_SVH

// Checked only outside reset.
`define BC_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("barometer_compensation check failed");

// Checked at every edge, reset included.
`define BC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("barometer_compensation check failed");

`endif

/* rtl/bcomp_pkg.sv */
// Types and constants for the barometer compensation block.
package bcomp_pkg;

  localparam int WORD_W = 32;
  localparam int UP_W = 19;

  typedef enum logic [2:0] {
    CFG_AC123 = 3'd0,
    CFG_AC456 = 3'd1,
    CFG_B1B2  = 3'd2,
    CFG_MCMD  = 3'd3,
    CFG_OSS   = 3'd4
  } bcomp_cfg_t;

  localparam logic [31:0] T_OFFSET  = 32'd4000;
  localparam logic [31:0] P_SQ_GAIN = 32'd3038;
  localparam logic [31:0] P_LIN_GAIN = 32'hFFFF_E343;
  localparam logic [31:0] P_BIAS    = 32'd3791;
  localparam logic [31:0] B7_SCALE  = 32'd50000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } bcomp_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } bcomp_out_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

/* rtl/bcomp_divider.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bcomp_divider #(
  parameter int SW = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [bcomp_pkg::WORD_W-1:0]    dividend,
  input  logic [bcomp_pkg::WORD_W-1:0]    divisor,
  input  logic [SW-1:0]                   sb_in,
  output logic                            out_valid,
  output logic [bcomp_pkg::WORD_W-1:0]    quotient,
  output logic [SW-1:0]                   sb_out
);
  import bcomp_pkg::*;

  logic              v   [0:WORD_W];
  logic [WORD_W-1:0] rem [0:WORD_W];
  logic [WORD_W-1:0] num [0:WORD_W];
  logic [WORD_W-1:0] dv  [0:WORD_W];
  logic [SW-1:0]     sb  [0:WORD_W];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign num[0] = dividend;
  assign dv[0]  = divisor;
  assign sb[0]  = sb_in;

  for (genvar k = 0; k < WORD_W; k++) begin : g_stage
    logic [WORD_W:0] trial;
    logic            ge;
    assign trial = {rem[k], num[k][WORD_W-1]};
    assign ge = trial >= {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? WORD_W'(trial - {1'b0, dv[k]}) : trial[WORD_W-1:0];
        num[k+1] <= {num[k][WORD_W-2:0], ge};
        dv[k+1]  <= dv[k];
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_valid = v[WORD_W];
  assign quotient  = num[WORD_W];
  assign sb_out    = sb[WORD_W];

endmodule

/* rtl/barometer_compensation.sv */
// Barometer temperature and pressure compensation pipeline, top level.
// Each request carries one raw temperature and pressure pair and produces one
// result; a new request is taken every cycle unless the output stalls, and each
// result passes through two 32-stage divider pipelines on its way out. The whole
// pipeline holds while a finished result waits at the output. Coefficients
// must be written only while no request is in flight; the block does not enforce this.
`include "barometer_compensation_assert.svh"

module barometer_compensation (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  bcomp_pkg::bcomp_in_t   sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output bcomp_pkg::bcomp_out_t  result,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [47:0]            cfg_data
);
  import bcomp_pkg::*;

  logic [47:0] ac123, ac456;
  logic [31:0] b1b2, mcmd;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac123 <= '0;
      ac456 <= '0;
      b1b2  <= '0;
      mcmd  <= '0;
      oss   <= 2'd3;
    end else if (cfg_write) begin
      case (bcomp_cfg_t'(cfg_index))
        CFG_AC123: ac123 <= cfg_data;
        CFG_AC456: ac456 <= cfg_data;
        CFG_B1B2:  b1b2  <= cfg_data[31:0];
        CFG_MCMD:  mcmd  <= cfg_data[31:0];
        CFG_OSS:   oss   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(ac123[47:32]);
  assign ac2 = sx16(ac123[31:16]);
  assign ac3 = sx16(ac123[15:0]);
  assign ac4 = {16'd0, ac456[47:32]};
  assign ac5 = {16'd0, ac456[31:16]};
  assign ac6 = {16'd0, ac456[15:0]};
  assign b1  = sx16(b1b2[31:16]);
  assign b2  = sx16(b1b2[15:0]);
  assign mc  = sx16(mcmd[31:16]);
  assign md  = sx16(mcmd[15:0]);

  logic en;
  assign en = !result_valid || result_ready;
  assign sample_ready = en;

  logic s1_v, s2_v, s4_v, s5_v, s6_v, s7_v, s8_v, s9_v, s10_v, s11_v, s12_v;
  logic [31:0] s1_d, s2_x1;
  logic [UP_W-1:0] s1_up, s2_up, s4_up, s5_up, s6_up, s7_up, s8_up;
  logic [23:0] up_shift;
  assign up_shift = sample.raw_pressure >> (4'd8 - {2'b00, oss});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v <= sample_valid;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d  <= {16'd0, sample.raw_temperature} - ac6;
      s1_up <= up_shift[UP_W-1:0];
      s2_x1 <= asr32(32'(s1_d * ac5), 5'd15);
      s2_up <= s1_up;
    end
  end

  localparam int SB1_W = 32 + UP_W + 2;
  logic [31:0] den, tnum;
  logic [31:0] den_abs, tnum_abs;
  logic [SB1_W-1:0] sb1_in, sb1_out;
  logic d1_v;
  logic [31:0] d1_q;
  assign den = s2_x1 + md;
  assign tnum = {mc[20:0], 11'd0};
  assign den_abs = den[31] ? 32'(0 - den) : den;
  assign tnum_abs = tnum[31] ? 32'(0 - tnum) : tnum;
  assign sb1_in = {s2_x1, s2_up, den == 32'd0, den[31] ^ tnum[31]};

  bcomp_divider #(.SW(SB1_W)) u_tdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(s2_v),
    .dividend(tnum_abs), .divisor(den_abs), .sb_in(sb1_in),
    .out_valid(d1_v), .quotient(d1_q), .sb_out(sb1_out)
  );

  logic [31:0] x1t, x2t, b5;
  logic neg1, err1;
  assign x1t  = sb1_out[SB1_W-1 -: 32];
  assign err1 = sb1_out[1];
  assign neg1 = sb1_out[0];
  assign x2t  = neg1 ? 32'(0 - d1_q) : d1_q;
  assign b5   = x1t + x2t;

  logic [31:0] s4_temp, s4_b6, s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic s4_err, s5_err, s6_err, s7_err, s8_err, s9_err, s10_err;
  logic [31:0] s5_sqr, s5_a2, s5_a3, s6_sq, s6_a2, s6_a3, s7_m1, s7_m2, s7_a2, s7_a3;
  logic [31:0] s8_b3, s8_x3, s9_b4, s9_t, s10_b7, s10_b4;
  logic [31:0] x3a, x3b, b3c;
  logic [31:0] ac1_x4;
  assign ac1_x4 = {ac1[29:0], 2'b00};
  assign x3a = asr32(s7_m1, 5'd11) + asr32(s7_a2, 5'd11);
  assign b3c = asr32(32'((ac1_x4 + x3a) << oss) + 32'd2, 5'd2);
  assign x3b = asr32(asr32(s7_a3, 5'd13) + asr32(s7_m2, 5'd16) + 32'd2, 5'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
      s8_v <= 1'b0;
      s9_v <= 1'b0;
      s10_v <= 1'b0;
    end else if (en) begin
      s4_v <= d1_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
      s8_v <= s7_v;
      s9_v <= s8_v;
      s10_v <= s9_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_temp <= asr32(b5 + 32'd8, 5'd4);
      s4_b6   <= b5 - T_OFFSET;
      s4_up   <= sb1_out[UP_W+1:2];
      s4_err  <= err1;

      s5_sqr  <= 32'(s4_b6 * s4_b6);
      s5_a2   <= 32'(ac2 * s4_b6);
      s5_a3   <= 32'(ac3 * s4_b6);
      s5_temp <= s4_temp;
      s5_up   <= s4_up;
      s5_err  <= s4_err;

      s6_sq   <= asr32(s5_sqr, 5'd12);
      s6_a2   <= s5_a2;
      s6_a3   <= s5_a3;
      s6_temp <= s5_temp;
      s6_up   <= s5_up;
      s6_err  <= s5_err;

      s7_m1   <= 32'(b2 * s6_sq);
      s7_m2   <= 32'(b1 * s6_sq);
      s7_a2   <= s6_a2;
      s7_a3   <= s6_a3;
      s7_temp <= s6_temp;
      s7_up   <= s6_up;
      s7_err  <= s6_err;

      s8_b3   <= b3c;
      s8_x3   <= x3b;
      s8_temp <= s7_temp;
      s8_up   <= s7_up;
      s8_err  <= s7_err;

      s9_b4   <= 32'(ac4 * (s8_x3 + B4_BIAS)) >> 15;
      s9_t    <= {{(32 - UP_W){1'b0}}, s8_up} - s8_b3;
      s9_temp <= s8_temp;
      s9_err  <= s8_err;

      s10_b7   <= 32'(s9_t * (B7_SCALE >> oss));
      s10_b4   <= s9_b4;
      s10_temp <= s9_temp;
      s10_err  <= s9_err || (s9_b4 == 32'd0);
    end
  end

  localparam int SB2_W = 34;
  logic [31:0] pnum, d2_q;
  logic [SB2_W-1:0] sb2_in, sb2_out;
  logic d2_v;
  assign pnum = s10_b7[31] ? s10_b7 : {s10_b7[30:0], 1'b0};
  assign sb2_in = {s10_temp, s10_err, s10_b7[31]};

  bcomp_divider #(.SW(SB2_W)) u_pdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(s10_v),
    .dividend(pnum), .divisor(s10_b4), .sb_in(sb2_in),
    .out_valid(d2_v), .quotient(d2_q), .sb_out(sb2_out)
  );

  logic [31:0] p0, ps;
  assign p0 = sb2_out[0] ? {d2_q[30:0], 1'b0} : d2_q;
  assign ps = asr32(p0, 5'd8);

  logic [31:0] s11_p, s11_sq, s11_y, s11_temp, s12_p, s12_x1, s12_x2, s12_temp;
  logic s11_err, s12_err;
  logic [31:0] p_corr;
  assign p_corr = asr32(s12_x1 + s12_x2 + P_BIAS, 5'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_v <= 1'b0;
      s12_v <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s11_v <= d2_v;
      s12_v <= s11_v;
      result_valid <= s12_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_p    <= p0;
      s11_sq   <= 32'(ps * ps);
      s11_y    <= 32'(P_LIN_GAIN * p0);
      s11_temp <= sb2_out[SB2_W-1 -: 32];
      s11_err  <= sb2_out[1];

      s12_p    <= s11_p;
      s12_x1   <= asr32(32'(s11_sq * P_SQ_GAIN), 5'd16);
      s12_x2   <= asr32(s11_y, 5'd16);
      s12_temp <= s11_temp;
      s12_err  <= s11_err;

      result.divide_error       <= s12_err;
      result.temperature_tenths <= s12_err ? '0 : s12_temp;
      result.pressure_pa        <= s12_err ? '0 : s12_p + p_corr;
    end
  end

  logic result_zero;
  assign result_zero = result.temperature_tenths == 0 && result.pressure_pa == 0;

  `BC_ASSERT_RUN(a_err_zero, result_valid && result.divide_error |-> result_zero)
  `BC_ASSERT_RUN(a_ready_rule, sample_ready == (!result_valid || result_ready))
  `BC_ASSERT_RUN(a_hold, result_valid && !result_ready |=> result_valid && $stable(result))
  `BC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !result_valid)

endmodule
